[src/bounded_set_span_tracker_defines.svh]
// Assertion macros for the bounded set span tracker checker.
// Depends on nothing; included by the checker file.
`ifndef BOUNDED_SET_SPAN_TRACKER_DEFINES_SVH
`define BOUNDED_SET_SPAN_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bsst_pkg.sv]
// Shared widths, defaults and status codes for the bounded set span tracker.
// Depends on nothing.
package bsst_pkg;

   localparam int unsigned DEFAULT_MAX_ENTRIES = 1024;
   localparam int unsigned VALUE_W             = 32;
   localparam int unsigned CAP_W               = 11;
   localparam int unsigned STATUS_W            = 2;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ADDED    = 2'd0,
      STATUS_INVERTED = 2'd1,
      STATUS_NO_ROOM  = 2'd2,
      STATUS_PRESENT  = 2'd3
   } status_type;

endpackage

[src/bounded_set_span_tracker.sv]
// Flow: inverted or no-room beats go from idle straight to report; an add scans
// for its insert position (ending in report if present), shifts later values up,
// fills the new values and reports, bound by the single value memory port pair.
// Throughput: one beat at a time; the next start is taken in the result cycle.
// Reset: synchronous; clears count and the min/max, sets gap to all ones and
// capacity to 1024; value memory kept. Results cannot be stalled by the receiver.
module bounded_set_span_tracker
   import bsst_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_first_value,
   input  logic [VALUE_W-1:0]  req_last_value,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CAP_W-1:0]    rsp_value_count,
   output logic                rsp_span_valid,
   output logic [VALUE_W-1:0]  rsp_shortest_span,
   output logic [VALUE_W-1:0]  rsp_longest_span,
   input  logic                csr_wr_en,
   input  logic [CAP_W-1:0]    csr_wr_data
);

   localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned WW = VALUE_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FILL,
      ST_REPORT
   } state_type;

   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [VALUE_W-1:0] smallest_ff, smallest_in;
   logic [VALUE_W-1:0] largest_ff, largest_in;
   logic [VALUE_W-1:0] gap_ff, gap_in;
   status_type         status_ff, status_in;

   logic [VALUE_W-1:0] first_ff, first_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [CW-1:0]      chk_idx_ff, chk_idx_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;
   logic               has_prev_ff, has_prev_in;
   logic [VALUE_W-1:0] next_ff, next_in;
   logic               has_next_ff, has_next_in;
   logic [CW-1:0]      p_ff, p_in;
   logic [CW-1:0]      sh_ff, sh_in;
   logic               sh_more_ff, sh_more_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      pend_idx_ff, pend_idx_in;
   logic [CW-1:0]      fk_ff, fk_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [CAP_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_span_valid_ff, rsp_span_valid_in;
   logic [VALUE_W-1:0] rsp_shortest_ff, rsp_shortest_in;
   logic [VALUE_W-1:0] rsp_longest_ff, rsp_longest_in;

   logic [VALUE_W-1:0] mem [MAX_ENTRIES];
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] rd_data_ff;

   logic [WW-1:0]      size_w, cap_w, max_w, lim_w, cnt_w;
   logic               no_room;
   logic [CW-1:0]      shift_dst, fill_dst;
   logic [CW+CAP_W-1:0] count_wide;
   logic [VALUE_W-1:0] gap_new, d_lo, d_hi;
   logic               span_ok;

   assign size_w  = WW'(req_last_value) - WW'(req_first_value) + WW'(1);
   assign cap_w   = WW'(capacity_ff);
   assign max_w   = WW'(MAX_ENTRIES);
   assign lim_w   = (cap_w > max_w) ? max_w : cap_w;
   assign cnt_w   = WW'(count_ff);
   assign no_room = (cnt_w > lim_w) || (size_w > (lim_w - cnt_w));

   assign shift_dst  = pend_idx_ff + n_ff;
   assign fill_dst   = p_ff + fk_ff;
   assign count_wide = (CW + CAP_W)'(count_ff);
   assign span_ok    = count_ff >= CW'(2);

   assign d_lo = first_ff - prev_ff;
   assign d_hi = next_ff - last_ff;

   always_comb begin
      gap_new = gap_ff;
      if (n_ff >= CW'(2)) begin
         gap_new = VALUE_W'(1);
      end
      if (has_prev_ff && (d_lo < gap_new)) begin
         gap_new = d_lo;
      end
      if (has_next_ff && (d_hi < gap_new)) begin
         gap_new = d_hi;
      end
   end

   always_comb begin
      state_in          = state_ff;
      capacity_in       = capacity_ff;
      count_in          = count_ff;
      smallest_in       = smallest_ff;
      largest_in        = largest_ff;
      gap_in            = gap_ff;
      status_in         = status_ff;
      first_in          = first_ff;
      last_in           = last_ff;
      n_in              = n_ff;
      iss_in            = iss_ff;
      chk_vld_in        = 1'b0;
      chk_idx_in        = chk_idx_ff;
      prev_in           = prev_ff;
      has_prev_in       = has_prev_ff;
      next_in           = next_ff;
      has_next_in       = has_next_ff;
      p_in              = p_ff;
      sh_in             = sh_ff;
      sh_more_in        = sh_more_ff;
      pend_in           = 1'b0;
      pend_idx_in       = pend_idx_ff;
      fk_in             = fk_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_span_valid_in = rsp_span_valid_ff;
      rsp_shortest_in   = rsp_shortest_ff;
      rsp_longest_in    = rsp_longest_ff;
      rd_addr           = '0;
      wr_en             = 1'b0;
      wr_addr           = fill_dst[AW-1:0];
      wr_data           = first_ff + VALUE_W'(fk_ff);

      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               first_in    = req_first_value;
               last_in     = req_last_value;
               n_in        = size_w[CW-1:0];
               iss_in      = '0;
               p_in        = '0;
               fk_in       = '0;
               has_prev_in = 1'b0;
               has_next_in = 1'b0;
               if (req_last_value < req_first_value) begin
                  status_in = STATUS_INVERTED;
                  state_in  = ST_REPORT;
               end else if (no_room) begin
                  status_in = STATUS_NO_ROOM;
                  state_in  = ST_REPORT;
               end else if (count_ff == '0) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = iss_ff[AW-1:0];
            if (iss_ff < count_ff) begin
               iss_in     = iss_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff;
            end
            if (chk_vld_ff) begin
               if (rd_data_ff >= first_ff) begin
                  p_in        = chk_idx_ff;
                  next_in     = rd_data_ff;
                  has_next_in = 1'b1;
                  chk_vld_in  = 1'b0;
                  if (rd_data_ff <= last_ff) begin
                     status_in = STATUS_PRESENT;
                     state_in  = ST_REPORT;
                  end else begin
                     sh_in      = count_ff - CW'(1);
                     sh_more_in = 1'b1;
                     state_in   = ST_SHIFT;
                  end
               end else begin
                  prev_in     = rd_data_ff;
                  has_prev_in = 1'b1;
                  if ((chk_idx_ff + CW'(1)) == count_ff) begin
                     p_in       = count_ff;
                     chk_vld_in = 1'b0;
                     state_in   = ST_FILL;
                  end
               end
            end
         end
         ST_SHIFT: begin
            rd_addr = sh_ff[AW-1:0];
            if (sh_more_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = sh_ff;
               if (sh_ff == p_ff) begin
                  sh_more_in = 1'b0;
               end else begin
                  sh_in = sh_ff - CW'(1);
               end
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[AW-1:0];
               wr_data = rd_data_ff;
               if (!sh_more_ff) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            wr_en = 1'b1;
            fk_in = fk_ff + CW'(1);
            if ((fk_ff + CW'(1)) == n_ff) begin
               count_in  = count_ff + n_ff;
               gap_in    = gap_new;
               status_in = STATUS_ADDED;
               state_in  = ST_REPORT;
               if (p_ff == '0) begin
                  smallest_in = first_ff;
               end
               if (!has_next_ff) begin
                  largest_in = last_ff;
               end
            end
         end
         ST_REPORT: begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = status_ff;
            rsp_count_in      = count_wide[CAP_W-1:0];
            rsp_span_valid_in = span_ok;
            rsp_shortest_in   = span_ok ? gap_ff : '0;
            rsp_longest_in    = span_ok ? (largest_ff - smallest_ff) : '0;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         smallest_ff  <= '0;
         largest_ff   <= '0;
         gap_ff       <= '1;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         sh_more_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         smallest_ff  <= smallest_in;
         largest_ff   <= largest_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         pend_ff      <= pend_in;
         sh_more_ff   <= sh_more_in;
      end
      status_ff         <= status_in;
      first_ff          <= first_in;
      last_ff           <= last_in;
      n_ff              <= n_in;
      iss_ff            <= iss_in;
      chk_idx_ff        <= chk_idx_in;
      prev_ff           <= prev_in;
      has_prev_ff       <= has_prev_in;
      next_ff           <= next_in;
      has_next_ff       <= has_next_in;
      p_ff              <= p_in;
      sh_ff             <= sh_in;
      pend_idx_ff       <= pend_idx_in;
      fk_ff             <= fk_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_span_valid_ff <= rsp_span_valid_in;
      rsp_shortest_ff   <= rsp_shortest_in;
      rsp_longest_ff    <= rsp_longest_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value_count   = rsp_count_ff;
   assign rsp_span_valid    = rsp_span_valid_ff;
   assign rsp_shortest_span = rsp_shortest_ff;
   assign rsp_longest_span  = rsp_longest_ff;

endmodule

[src/bsst_checker.sv]
// Port-level checker for the bounded set span tracker, with its bind.
// Depends on bsst_pkg and bounded_set_span_tracker_defines.svh.
`include "bounded_set_span_tracker_defines.svh"

module bsst_checker
   import bsst_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [VALUE_W-1:0]  req_first_value,
   input logic [VALUE_W-1:0]  req_last_value,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [CAP_W-1:0]    rsp_value_count,
   input logic                rsp_span_valid,
   input logic [VALUE_W-1:0]  rsp_shortest_span,
   input logic [VALUE_W-1:0]  rsp_longest_span,
   input logic                csr_wr_en,
   input logic [CAP_W-1:0]    csr_wr_data
);

   `BSST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "beat accepted but not busy")

   `BSST_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result shown while busy")

   `BSST_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result repeated")

   `BSST_ASSERT_NOW(a_done_with_rsp, clock, reset, $fell(busy) && !$past(reset), rsp_valid, "busy dropped without a result")

   `BSST_ASSERT_NOW(a_span_zero, clock, reset, rsp_valid && !rsp_span_valid, (rsp_shortest_span == '0) && (rsp_longest_span == '0), "spans nonzero while invalid")

endmodule

bind bounded_set_span_tracker bsst_checker u_bsst_checker (.*);

[tb/sv/bounded_set_span_tracker_tb.sv]
// Self-checking testbench for the bounded set span tracker: a directed table, then
// random range adds over several capacity settings, checked against the table or a predictor.
// Depends on bsst_pkg and the bounded_set_span_tracker RTL.
module bounded_set_span_tracker_tb
   import bsst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SET_DEPTH    = DEFAULT_MAX_ENTRIES;
   localparam int unsigned CAP_MAX      = 2047;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_BEATS  = 34;

   typedef struct packed {
      status_type         status;
      logic [CAP_W-1:0]   count;
      logic               span_ok;
      logic [VALUE_W-1:0] shortest;
      logic [VALUE_W-1:0] longest;
   } span_report_type;

   typedef enum logic {ROW_BEAT, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [VALUE_W-1:0] first;
      logic [VALUE_W-1:0] last;
      bit                 typed;
      span_report_type    want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [VALUE_W-1:0]  req_first_value = '0;
   logic [VALUE_W-1:0]  req_last_value = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [CAP_W-1:0]    rsp_value_count;
   logic                rsp_span_valid;
   logic [VALUE_W-1:0]  rsp_shortest_span;
   logic [VALUE_W-1:0]  rsp_longest_span;
   logic                csr_wr_en = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data = '0;

   bounded_set_span_tracker #(.MAX_ENTRIES(SET_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_first_value   (req_first_value),
      .req_last_value    (req_last_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_value_count   (rsp_value_count),
      .rsp_span_valid    (rsp_span_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the sorted set and its spans
   logic [VALUE_W-1:0] set_vals [SET_DEPTH];
   int unsigned        set_count = 0;
   logic [VALUE_W-1:0] set_min = '0;
   logic [VALUE_W-1:0] set_max = '0;
   logic [VALUE_W-1:0] set_gap = '1;
   int unsigned        cap_model = CAPACITY_RESET;

   span_report_type pending_reports [$];
   stim_row_type    directed [$];
   bit              typed_valid = 1'b0;
   span_report_type typed_report;
   int unsigned     fail_count = 0;
   int unsigned     beats_taken = 0;
   int unsigned     cap_writes = 0;
   int unsigned     status_tally [4] = '{0, 0, 0, 0};

   function automatic span_report_type apply_range_add(logic [VALUE_W-1:0] lo,
                                                       logic [VALUE_W-1:0] hi);
      status_type         st;
      logic [VALUE_W:0]   size;
      int unsigned        lim, pos, n, old, i, k;
      logic [VALUE_W-1:0] gap;
      span_report_type    r;
      st = STATUS_ADDED;
      if (hi < lo) begin
         st = STATUS_INVERTED;
      end else begin
         size = {1'b0, hi - lo} + 33'd1;
         lim = (cap_model > SET_DEPTH) ? SET_DEPTH : cap_model;
         if (set_count > lim || size > (lim - set_count)) begin
            st = STATUS_NO_ROOM;
         end else begin
            pos = 0;
            while (pos < set_count && set_vals[pos] < lo) pos++;
            if (pos < set_count && set_vals[pos] <= hi) begin
               st = STATUS_PRESENT;
            end else begin
               n = size[VALUE_W-1:0];
               old = set_count;
               gap = set_gap;
               for (i = old; i > pos; i--) set_vals[i - 1 + n] = set_vals[i - 1];
               for (k = 0; k < n; k++) set_vals[pos + k] = lo + k;
               set_count = old + n;
               if (n >= 2) gap = 1;
               if (pos > 0 && lo - set_vals[pos - 1] < gap) gap = lo - set_vals[pos - 1];
               if (pos < old && set_vals[pos + n] - hi < gap) gap = set_vals[pos + n] - hi;
               set_gap = gap;
               set_min = set_vals[0];
               set_max = set_vals[set_count - 1];
            end
         end
      end
      r.status   = st;
      r.count    = set_count[CAP_W-1:0];
      r.span_ok  = (set_count >= 2);
      r.shortest = r.span_ok ? set_gap : '0;
      r.longest  = r.span_ok ? set_max - set_min : '0;
      return r;
   endfunction

   task automatic check_report(span_report_type want, span_report_type got);
      if (got.status !== want.status) begin
         $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, got.status);
         fail_count++;
      end
      if (got.count !== want.count) begin
         $display("%0t: value_count mismatch, expected %0d, got %0d", $time, want.count,
                  got.count);
         fail_count++;
      end
      if (got.span_ok !== want.span_ok) begin
         $display("%0t: span_valid mismatch, expected %0b, got %0b", $time, want.span_ok,
                  got.span_ok);
         fail_count++;
      end
      if (got.shortest !== want.shortest) begin
         $display("%0t: shortest_span mismatch, expected %h, got %h", $time, want.shortest,
                  got.shortest);
         fail_count++;
      end
      if (got.longest !== want.longest) begin
         $display("%0t: longest_span mismatch, expected %h, got %h", $time, want.longest,
                  got.longest);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      span_report_type got, want;
      if (!reset) begin
         if (rsp_valid) begin
            got.status   = status_type'(rsp_status);
            got.count    = rsp_value_count;
            got.span_ok  = rsp_span_valid;
            got.shortest = rsp_shortest_span;
            got.longest  = rsp_longest_span;
            if (pending_reports.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, got status %0d count %0d",
                        $time, got.status, got.count);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               check_report(want, got);
            end
         end
         if (csr_wr_en) cap_model = csr_wr_data;
         if (start && !busy) begin
            want = apply_range_add(req_first_value, req_last_value);
            if (typed_valid) want = typed_report;
            status_tally[want.status]++;
            beats_taken++;
            pending_reports = {pending_reports, want};
         end
      end
   end

   function automatic stim_row_type mk_row(row_kind_type kind, logic [VALUE_W-1:0] f,
                                           logic [VALUE_W-1:0] l, bit typed = 1'b0,
                                           status_type st = STATUS_ADDED, int unsigned cnt = 0,
                                           bit ok = 1'b0, logic [VALUE_W-1:0] sh = '0,
                                           logic [VALUE_W-1:0] lg = '0);
      stim_row_type row;
      row.kind          = kind;
      row.first         = f;
      row.last          = l;
      row.typed         = typed;
      row.want.status   = st;
      row.want.count    = cnt[CAP_W-1:0];
      row.want.span_ok  = ok;
      row.want.shortest = sh;
      row.want.longest  = lg;
      return row;
   endfunction

   task automatic queue_row(stim_row_type row);
      directed = {directed, row};
   endtask

   function automatic int unsigned pick_gap(bit allow);
      if (allow && $urandom_range(0, 2) == 0) begin
         return $urandom_range(1, 14);
      end
      return 0;
   endfunction

   task automatic pick_range(output logic [VALUE_W-1:0] f, output logic [VALUE_W-1:0] l);
      int unsigned        r, sz, idx;
      logic [VALUE_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         f = $urandom_range(32'hFFFF_FFFF, 1);
         l = $urandom_range(f - 1, 0);
      end else if (r < 12) begin
         f = $urandom_range(0, 1000);
         l = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
      end else if (r < 16) begin
         if (r[0]) begin
            f = 32'hFFFF_FFFF - $urandom_range(0, 6);
            l = f + $urandom_range(0, 32'hFFFF_FFFF - f);
         end else begin
            f = $urandom_range(0, 6);
            l = f + $urandom_range(0, 2);
         end
      end else if (r < 34 && set_count > 0) begin
         idx = $urandom_range(0, set_count - 1);
         v = set_vals[idx];
         if (r < 25) begin
            f = (v > 3) ? v - $urandom_range(0, 3) : v;
            l = (v < 32'hFFFF_FFFC) ? v + $urandom_range(0, 3) : v;
         end else begin
            if ((r[0] && v != 32'hFFFF_FFFF) || v == 0) f = v + 1;
            else f = v - 1;
            l = f;
         end
      end else begin
         sz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 32);
         f = $urandom;
         if (f > 32'hFFFF_FFFF - (sz - 1)) f = 32'hFFFF_FFFF - (sz - 1);
         l = f + sz - 1;
      end
   endtask

   // Hold start until the beat is taken, then hold start low while the gap lasts
   task automatic send_beat(logic [VALUE_W-1:0] f, logic [VALUE_W-1:0] l, int unsigned gap);
      start <= 1'b1;
      req_first_value <= f;
      req_last_value <= l;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         req_first_value <= $urandom;
         req_last_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_reports();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   task automatic set_capacity(int unsigned c);
      csr_wr_en <= 1'b1;
      csr_wr_data <= c[CAP_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cap_writes++;
   endtask

   initial begin
      logic [VALUE_W-1:0] f, l;
      int unsigned        phase, k, cap, table_beats;
      queue_row(mk_row(ROW_BEAT, 5, 4, 1, STATUS_INVERTED));
      queue_row(mk_row(ROW_BEAT, 32'hFFFF_FFFF, 0, 1, STATUS_INVERTED));
      queue_row(mk_row(ROW_BEAT, 0, 32'hFFFF_FFFF, 1, STATUS_NO_ROOM));
      queue_row(mk_row(ROW_BEAT, 0, 1024, 1, STATUS_NO_ROOM));
      queue_row(mk_row(ROW_BEAT, 100, 100, 1, STATUS_ADDED, 1));
      queue_row(mk_row(ROW_BEAT, 100, 100, 1, STATUS_PRESENT, 1));
      queue_row(mk_row(ROW_BEAT, 0, 0, 1, STATUS_ADDED, 2, 1, 100, 100));
      queue_row(mk_row(ROW_BEAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_ADDED, 3, 1,
                       100, 32'hFFFF_FFFF));
      queue_row(mk_row(ROW_BEAT, 50, 99));
      queue_row(mk_row(ROW_BEAT, 90, 200));
      queue_row(mk_row(ROW_BEAT, 102, 105));
      queue_row(mk_row(ROW_BEAT, 32'hFFFF_FFF0, 32'hFFFF_FFFE));
      queue_row(mk_row(ROW_BEAT, 1, 49));
      queue_row(mk_row(ROW_BEAT, 101, 101));
      queue_row(mk_row(ROW_CAPACITY, 0, 0));
      queue_row(mk_row(ROW_BEAT, 7, 7));
      queue_row(mk_row(ROW_BEAT, 9, 3));
      queue_row(mk_row(ROW_BEAT, 100, 100));
      queue_row(mk_row(ROW_CAPACITY, CAP_MAX, 0));
      queue_row(mk_row(ROW_BEAT, 300, 300));
      queue_row(mk_row(ROW_CAPACITY, 5, 0));
      queue_row(mk_row(ROW_BEAT, 400, 400));
      queue_row(mk_row(ROW_BEAT, 0, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[j]) begin
         if (directed[j].kind == ROW_CAPACITY) begin
            drain_reports();
            set_capacity(directed[j].first);
         end else begin
            typed_valid = directed[j].typed;
            typed_report = directed[j].want;
            send_beat(directed[j].first, directed[j].last, pick_gap(1'b1));
            typed_valid = 1'b0;
         end
      end
      table_beats = beats_taken;

      for (phase = 0; phase < PHASES; phase++) begin
         drain_reports();
         case (phase)
            0: begin
               cap = CAPACITY_RESET;
            end
            1: begin
               cap = set_count + $urandom_range(0, 24);
            end
            2: begin
               cap = CAP_MAX;
            end
            3: begin
               cap = set_count / 2;
            end
            4: begin
               cap = $urandom_range(0, CAP_MAX);
            end
            5: begin
               cap = set_count + $urandom_range(1, 60);
            end
            6: begin
               cap = 0;
            end
            default: begin
               cap = CAPACITY_RESET;
            end
         endcase
         if (cap > CAP_MAX) cap = CAP_MAX;
         set_capacity(cap);
         for (k = 0; k < PHASE_BEATS; k++) begin
            pick_range(f, l);
            send_beat(f, l, pick_gap(phase < PHASES - 1 && (k % 24) >= 6));
         end
      end

      drain_reports();
      repeat (32) @(negedge clock);
      $display("Ran %0d beats (%0d from the table) over %0d capacity writes; set ended at %0d values.",
               beats_taken, table_beats, cap_writes, set_count);
      $display("Outcomes: %0d added, %0d inverted, %0d no room, %0d already present.",
               status_tally[STATUS_ADDED], status_tally[STATUS_INVERTED],
               status_tally[STATUS_NO_ROOM], status_tally[STATUS_PRESENT]);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results still outstanding", pending_reports.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/bsst_pkg.sv
src/bounded_set_span_tracker.sv
src/bsst_checker.sv
tb/sv/bounded_set_span_tracker_tb.sv
